// ----- design/lpct_pkg.sv -----
// Shared constants and types for the linear-probe connection table.
`timescale 1ns / 1ps
package lpct_pkg;

  localparam int Slots    = 256;
  localparam int IdxW     = $clog2(Slots);
  localparam int IdW      = 16;
  localparam int StatusW  = 3;
  localparam int SlotW    = 8;
  localparam int InDataW  = 2 * IdW;
  localparam int OutDataW = 16;
  localparam int OutPadW  = OutDataW - StatusW - SlotW;

  typedef enum logic [StatusW-1:0] {
    StAdded    = 3'd0,
    StFound    = 3'd1,
    StTimeout  = 3'd2,
    StNotFound = 3'd3,
    StFull     = 3'd4
  } status_e;

  typedef struct packed {
    logic [IdW-1:0] socket_id;
    logic [IdW-1:0] timer_id;
  } entry_t;

endpackage

// ----- design/linear_probe_connection_table_top.sv -----
// Linear-probe connection table: add and query engine over one entry memory.
//
//  channel   dir  tdata (low bit up)           tuser
//  s_axis    in   key_id[15:0], timer_id[31:16] action (0 add, 1 query)
//  m_axis    out  status[2:0], slot[10:3], 0    -
//
// One request at a time; the entry memory is read one slot per cycle while
// no result stalls on m_axis, and the compare works on the registered read.
// An add or a query that hits in its chain probes up to Slots slots in it.
// A query that misses in its chain goes on to a scan of up to Slots slots.
// Reset clears all occupied marks at once; no clearing pass is needed.
// While a result waits on m_axis the engine holds its probe in place, so
// a stall holds up the request in flight.
`timescale 1ns / 1ps
module linear_probe_connection_table_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // key_id[15:0], timer_id[31:16]
  input  logic [lpct_pkg::InDataW-1:0]  s_axis_tdata_i,
  // action[0]
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status[2:0], slot[10:3], zero pad[15:11]
  output logic [lpct_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import lpct_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StScan = 2'd2;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Slots - 1);

  entry_t              mem [Slots];
  entry_t              rd_q;
  logic                occ_rd_q;
  logic [Slots-1:0]    valid_q;

  logic [1:0]          state_q, state_d;
  logic                vld_q, vld_d;
  logic [IdxW-1:0]     rd_addr_q, rd_addr_d;
  logic [IdxW-1:0]     cmp_addr_q, cmp_addr_d;
  logic [IdxW-1:0]     n_q, n_d;
  logic [IdxW-1:0]     raddr;
  logic                act_q;
  logic [IdW-1:0]      key_q, tmr_q;
  logic                m_tvalid_q;
  logic [OutDataW-1:0] m_tdata_q;

  logic                s_accept;
  logic                frozen;
  logic                finish;
  logic                we;
  logic                clr_valid;
  logic                zero_slot;
  status_e             res_status;
  logic [IdxW-1:0]     home;
  logic [IdW-1:0]      e_tmr;
  logic [31:0]         slot_wide;
  logic [SlotW-1:0]    res_slot;

  assign s_axis_tready_o = (state_q == StIdle);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign frozen          = m_tvalid_q && !m_axis_tready_i;
  assign home            = s_axis_tdata_i[IdxW-1:0];
  assign e_tmr           = occ_rd_q ? rd_q.timer_id : '0;

  always_comb begin
    state_d    = state_q;
    vld_d      = vld_q;
    rd_addr_d  = rd_addr_q;
    cmp_addr_d = cmp_addr_q;
    n_d        = n_q;
    raddr      = rd_addr_q;
    finish     = 1'b0;
    we         = 1'b0;
    clr_valid  = 1'b0;
    zero_slot  = 1'b0;
    res_status = StNotFound;
    unique case (state_q)
      StIdle: begin
        raddr = home;
        vld_d = 1'b0;
        if (s_accept) begin
          rd_addr_d  = home + IdxW'(1);
          cmp_addr_d = home;
          vld_d      = 1'b1;
          n_d        = '0;
          state_d    = StWalk;
        end
      end
      StWalk: begin
        if (frozen) begin
          // re-read the slot under compare so its data is fresh on release
          raddr = cmp_addr_q;
        end else begin
          cmp_addr_d = rd_addr_q;
          rd_addr_d  = rd_addr_q + IdxW'(1);
          vld_d      = 1'b1;
          if (vld_q) begin
            if (!act_q) begin
              if (!occ_rd_q) begin
                finish     = 1'b1;
                we         = 1'b1;
                res_status = StAdded;
              end else if (n_q == LastIdx) begin
                finish     = 1'b1;
                zero_slot  = 1'b1;
                res_status = StFull;
              end else begin
                n_d = n_q + IdxW'(1);
              end
            end else begin
              if (occ_rd_q && rd_q.socket_id == key_q) begin
                finish     = 1'b1;
                res_status = StFound;
              end else if (occ_rd_q && rd_q.timer_id == key_q) begin
                finish     = 1'b1;
                clr_valid  = 1'b1;
                res_status = StTimeout;
              end else if (!occ_rd_q || n_q == LastIdx) begin
                // chain ended without a match: scan every timer id from slot zero
                state_d   = StScan;
                rd_addr_d = '0;
                vld_d     = 1'b0;
              end else begin
                n_d = n_q + IdxW'(1);
              end
            end
          end
          if (finish) begin
            state_d = StIdle;
            vld_d   = 1'b0;
          end
        end
      end
      StScan: begin
        if (frozen) begin
          raddr = cmp_addr_q;
        end else begin
          cmp_addr_d = rd_addr_q;
          rd_addr_d  = rd_addr_q + IdxW'(1);
          vld_d      = 1'b1;
          if (vld_q) begin
            if (e_tmr == key_q) begin
              finish     = 1'b1;
              clr_valid  = 1'b1;
              res_status = StTimeout;
            end else if (cmp_addr_q == LastIdx) begin
              finish     = 1'b1;
              zero_slot  = 1'b1;
              res_status = StNotFound;
            end
          end
          if (finish) begin
            state_d = StIdle;
            vld_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = StIdle;
        vld_d   = 1'b0;
      end
    endcase
  end

  assign slot_wide = 32'(cmp_addr_q);
  assign res_slot  = zero_slot ? '0 : slot_wide[SlotW-1:0];

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[cmp_addr_q] <= '{socket_id: key_q, timer_id: tmr_q};
    end
    rd_q <= mem[raddr];
  end

  // occupied marks live in flops so reset empties the table at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      occ_rd_q <= 1'b0;
    end else begin
      if (we) begin
        valid_q[cmp_addr_q] <= 1'b1;
      end else if (clr_valid) begin
        valid_q[cmp_addr_q] <= 1'b0;
      end
      occ_rd_q <= valid_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      vld_q      <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      if (finish) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_d;
    cmp_addr_q <= cmp_addr_d;
    n_q        <= n_d;
    if (s_accept) begin
      act_q <= s_axis_tuser_i;
      key_q <= s_axis_tdata_i[IdW-1:0];
      tmr_q <= s_axis_tdata_i[InDataW-1:IdW];
    end
    if (finish) begin
      m_tdata_q <= {{OutPadW{1'b0}}, res_slot, res_status};
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

endmodule

// ----- design/lpct_checker.sv -----
// Port-level checks for the connection table, bound to the top level.
`timescale 1ns / 1ps
module lpct_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [lpct_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import lpct_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while engine busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[2:0] <= StFull)
    else $error("status code out of range");

  a_miss_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[2:0] == StNotFound || m_axis_tdata_o[2:0] == StFull)
      |-> m_axis_tdata_o[10:3] == '0)
    else $error("slot not zero on miss or full");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:11] == '0)
    else $error("result pad bits set");

endmodule

bind linear_probe_connection_table_top lpct_checker u_lpct_checker (.*);

// ----- bench/linear_probe_connection_table_top_test.sv -----
// Self-checking test of the linear-probe connection table over its request/reply streams.
`timescale 1ns / 1ps
module linear_probe_connection_table_top_test;
  import lpct_pkg::*;

  localparam logic ActAdd         = 1'b0;
  localparam logic ActQuery       = 1'b1;
  localparam int   LongHoldCycles = 300;
  localparam int   TailCycles     = 2 * Slots + 16;
  localparam int   WatchdogCycles = 8 * (2 * Slots + 16);
  localparam int   ReportLimit    = 10;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
  } outcome_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                s_axis_tuser_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  // Shadow copy of the connection table
  bit             tbl_used [Slots];
  bit [IdW-1:0]   tbl_sock [Slots];
  bit [IdW-1:0]   tbl_tmr  [Slots];
  int             live_count = 0;

  outcome_t       pending_outcomes[$];
  int             fail_count    = 0;
  int             quiet_cycles  = 0;
  bit             idle_on       = 1'b1;
  int             sink_hold_req = 0;
  logic [7:0]     hot_base      = '0;

  linear_probe_connection_table_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void drop_entry(input int s);
    if (tbl_used[s]) live_count--;
    tbl_used[s] = 1'b0;
    tbl_sock[s] = '0;
    tbl_tmr[s]  = '0;
  endfunction

  // Apply one request to the shadow table and return the reply it must produce.
  function automatic outcome_t table_outcome(input logic act, input logic [IdW-1:0] key,
                                             input logic [IdW-1:0] tmr);
    outcome_t res;
    int       s;
    int       n;
    bit       hit;
    res.status = StNotFound;
    res.slot   = '0;
    hit        = 1'b0;
    s          = key % Slots;
    if (act == ActAdd) begin
      res.status = StFull;
      for (n = 0; n < Slots && !hit; n++) begin
        if (!tbl_used[s]) begin
          tbl_used[s] = 1'b1;
          tbl_sock[s] = key;
          tbl_tmr[s]  = tmr;
          live_count++;
          res.status = StAdded;
          res.slot   = 8'(s);
          hit        = 1'b1;
        end else begin
          s = (s + 1) % Slots;
        end
      end
    end else begin
      // socket id is tested before timer id within one slot
      for (n = 0; n < Slots && !hit && tbl_used[s]; n++) begin
        if (tbl_sock[s] == key) begin
          res.status = StFound;
          res.slot   = 8'(s);
          hit        = 1'b1;
        end else if (tbl_tmr[s] == key) begin
          drop_entry(s);
          res.status = StTimeout;
          res.slot   = 8'(s);
          hit        = 1'b1;
        end else begin
          s = (s + 1) % Slots;
        end
      end
      // fall back to a scan of every timer id, empty slots included
      for (n = 0; n < Slots && !hit; n++) begin
        if (tbl_tmr[n] == key) begin
          drop_entry(n);
          res.status = StTimeout;
          res.slot   = 8'(n);
          hit        = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic int pick_live_slot();
    int start;
    int s;
    start = $urandom_range(0, Slots - 1);
    for (int k = 0; k < Slots; k++) begin
      s = (start + k) % Slots;
      if (tbl_used[s]) return s;
    end
    return -1;
  endfunction

  function automatic bit id_present(input logic [IdW-1:0] id);
    for (int s = 0; s < Slots; s++) begin
      if (tbl_used[s] && (tbl_sock[s] == id || tbl_tmr[s] == id)) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_request(input logic act, input logic [IdW-1:0] key,
                              input logic [IdW-1:0] tmr);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {tmr, key};
    s_axis_tuser_i  <= act;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    pending_outcomes.push_back(table_outcome(act, key, tmr));
  endtask

  // Drop the request valid and wait for every outstanding reply.
  task automatic drain_replies();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0);
  endtask

  task automatic random_request();
    int             add_pct;
    int             pick;
    int             s;
    logic [IdW-1:0] key;
    logic [IdW-1:0] tmr;
    add_pct = (live_count < 64) ? 60 : (live_count < 192) ? 45 : 25;
    pick    = $urandom_range(0, 99);
    s       = pick_live_slot();
    if ($urandom_range(0, 99) < add_pct) begin
      // cluster half of the adds around one home region to build long chains
      if ($urandom_range(0, 1)) key = IdW'($urandom);
      else key = {8'($urandom), hot_base + 8'($urandom_range(0, 7))};
      if (pick < 70 || s < 0) tmr = IdW'($urandom);
      else if (pick < 85) tmr = tbl_sock[s];
      else tmr = IdW'($urandom_range(0, 3));
      send_request(ActAdd, key, tmr);
    end else begin
      if (s >= 0 && pick < 35) key = tbl_sock[s];
      else if (s >= 0 && pick < 65) key = tbl_tmr[s];
      else if (pick < 73) key = '0;
      else key = IdW'($urandom);
      send_request(ActQuery, key, IdW'($urandom));
    end
  endtask

  task automatic test_directed();
    send_request(ActQuery, 16'h0000, 16'hFFFF);  // empty slot timer matches id zero
    send_request(ActQuery, 16'hFFFF, 16'h0000);
    send_request(ActAdd,   16'h0000, 16'hFFFF);
    send_request(ActAdd,   16'h0100, 16'h1234);
    send_request(ActAdd,   16'h0100, 16'h0001);  // duplicate socket id
    send_request(ActAdd,   16'hFFFF, 16'h8000);
    send_request(ActAdd,   16'h01FF, 16'h7FFF);  // wraps past the last slot
    send_request(ActQuery, 16'h0100, 16'h0000);
    send_request(ActQuery, 16'h01FF, 16'h0000);
    send_request(ActAdd,   16'h0005, 16'h0105);
    send_request(ActAdd,   16'h0105, 16'h0005);
    send_request(ActQuery, 16'h0105, 16'hAAAA);  // timer hit inside the chain
    send_request(ActQuery, 16'h0105, 16'h5555);
    send_request(ActAdd,   16'h0007, 16'h0007);
    send_request(ActQuery, 16'h0007, 16'h0000);  // socket wins over timer
    send_request(ActQuery, 16'h1234, 16'h0000);  // timer hit found by the scan
    send_request(ActQuery, 16'h0000, 16'h0000);
    send_request(ActQuery, 16'h8000, 16'h0000);
    send_request(ActQuery, 16'hFFFF, 16'h0000);
    send_request(ActQuery, 16'h0000, 16'h0000);
    drain_replies();
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        idle_on  = ($urandom_range(0, 3) != 0);
        hot_base = 8'($urandom);
      end
      random_request();
    end
    drain_replies();
  endtask

  task automatic test_backpressure();
    idle_on       = 1'b0;
    sink_hold_req = LongHoldCycles;
    repeat (24) random_request();
    drain_replies();
    idle_on = 1'b1;
  endtask

  task automatic test_full_table();
    logic [IdW-1:0] id;
    int             s;
    while (live_count < Slots) send_request(ActAdd, IdW'($urandom), IdW'($urandom));
    send_request(ActAdd, 16'h0000, 16'h0000);
    send_request(ActAdd, 16'hFFFF, 16'hFFFF);
    // every chain is occupied: walk the whole table, then scan
    do id = IdW'($urandom); while (id_present(id));
    send_request(ActQuery, id, 16'h0000);
    send_request(ActQuery, 16'h0000, 16'h0000);
    s = pick_live_slot();
    send_request(ActQuery, tbl_sock[s], 16'h0000);
    repeat (Slots / 2) begin
      s = pick_live_slot();
      if (s >= 0) send_request(ActQuery, tbl_tmr[s], IdW'($urandom));
    end
    drain_replies();
  endtask

  task automatic test_quiet_finish(input int count);
    idle_on = 1'b0;
    repeat (count) random_request();
    drain_replies();
  endtask

  // Reply consumer: random stalls, plus one long hold on request.
  initial begin : reply_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (sink_hold_req > 0) begin
        hold_left     = sink_hold_req - 1;
        sink_hold_req = 0;
        m_axis_tready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 3);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : reply_check
    outcome_t           want;
    logic [StatusW-1:0] got_status;
    logic [SlotW-1:0]   got_slot;
    if (rst_ni && m_axis_tvalid_o === 1'b1 && m_axis_tready_i) begin
      got_status = m_axis_tdata_o[StatusW-1:0];
      got_slot   = m_axis_tdata_o[StatusW +: SlotW];
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit)
          $display("%0t: unexpected reply status %0d slot %0d", $time, got_status, got_slot);
      end else begin
        want = pending_outcomes.pop_front();
        if (got_status !== want.status || got_slot !== want.slot) begin
          fail_count++;
          if (fail_count <= ReportLimit)
            $display("%0t: reply mismatch: want status %s slot %0d, got status %0d slot %0d",
                     $time, want.status.name(), want.slot, got_status, got_slot);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o === 1'b1) ||
        (m_axis_tvalid_o === 1'b1 && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogCycles) begin
      $display("%0t: no request or reply moved for %0d cycles", $time, quiet_cycles);
      $display("[linear_probe_connection_table_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix(1100);
    test_backpressure();
    test_full_table();
    test_quiet_finish(450);
    repeat (TailCycles) @(posedge clk_i);
    if (pending_outcomes.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("[linear_probe_connection_table_top] OK");
    end else begin
      $display("[linear_probe_connection_table_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- linear_probe_connection_table_top.f -----
design/lpct_pkg.sv
design/linear_probe_connection_table_top.sv
design/lpct_checker.sv
bench/linear_probe_connection_table_top_test.sv
